@@ hw/rtl/mqsb_pkg.sv @@
// mqsb_pkg: shared types and constants of the multi-queue shared buffer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mqsb_pkg;

  localparam int DATA_W = 32;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

endpackage

`default_nettype wire

@@ hw/rtl/multi_queue_shared_buffer.sv @@
// an accepted request's result is in the output register in the cycle after its accept
// throughput: one request per cycle while the output is not stalled; the pointer update of
// a request is done in its accept cycle, the next-slot lookups come from the link memory's
// registered read port and are prefetched into per-queue and free-list registers
// reset: all queues empty, free list from slot 0 upward; the link memory is covered by a
// fill counter, so there is no clearing pass; the data memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module multi_queue_shared_buffer
  import mqsb_pkg::*;
#(
  parameter int NUM_QUEUES  = 4,
  parameter int STORE_DEPTH = 16,
  localparam int QID_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int IDX_W = $clog2(STORE_DEPTH) + 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     cmd_i,
  input  wire logic [QID_W-1:0]         queue_id_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [1:0]                    status_o,
  output logic signed [DATA_W-1:0]      popped_value_o,
  output logic signed [IDX_W-1:0]       head_index_o,
  output logic signed [IDX_W-1:0]       tail_index_o
);

  localparam int SLOT_W = IDX_W - 1;
  localparam int FILL_W = $clog2(STORE_DEPTH + 1);

  typedef struct packed {
    logic              nil;
    logic [SLOT_W-1:0] idx;
  } ptr_t;

  localparam ptr_t PTR_NIL = '{nil: 1'b1, idx: '0};

  // queue tables and free list
  ptr_t              head_q [NUM_QUEUES];
  ptr_t              head_d [NUM_QUEUES];
  ptr_t              tail_q [NUM_QUEUES];
  ptr_t              tail_d [NUM_QUEUES];
  ptr_t              hnext_q [NUM_QUEUES];
  ptr_t              hnext_d [NUM_QUEUES];
  ptr_t              hnext_eff [NUM_QUEUES];
  ptr_t              free_q, free_d;
  ptr_t              fnext_q, fnext_d, fnext_eff;
  logic [FILL_W-1:0] fill_q, fill_d;

  // pending link lookups
  logic              pend_f_q, pend_f_d;
  logic              pend_h_q, pend_h_d;
  logic [QID_W-1:0]  pend_qid_q, pend_qid_d;

  // link memory
  ptr_t              link_mem [STORE_DEPTH];
  logic              lwe, lre;
  logic [SLOT_W-1:0] lwaddr, lraddr, laddr_q;
  ptr_t              lwdata, lrd_q, lnk_rd, lnk_virt;
  logic              lvirt_q;

  // data memory
  logic signed [DATA_W-1:0] data_mem [STORE_DEPTH];
  logic                     dwe, dre;
  logic [SLOT_W-1:0]        dwaddr, draddr;
  logic signed [DATA_W-1:0] drd_q;

  // request decode and result
  logic              acc, qid_ok;
  logic [QID_W-1:0]  qsel;
  ptr_t              cur_head, cur_tail, res_head, res_tail;
  status_e           st;
  logic              pop_ok;

  // output register
  logic              out_valid_q;
  status_e           status_q;
  logic              pop_ok_q;
  logic [IDX_W-1:0]  head_idx_q, tail_idx_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign acc        = in_valid_i & ~in_stall_o;
  assign qsel       = queue_id_i;
  assign qid_ok     = ({1'b0, queue_id_i} < (QID_W + 1)'(NUM_QUEUES));

  // slots at or above the fill count were never allocated and still link to the next slot
  assign lnk_virt = (laddr_q == SLOT_W'(STORE_DEPTH - 1)) ? PTR_NIL
                  : ptr_t'{nil: 1'b0, idx: SLOT_W'(laddr_q + 1'b1)};
  assign lnk_rd   = lvirt_q ? lnk_virt : lrd_q;

  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      hnext_eff[i] = (pend_h_q && (pend_qid_q == QID_W'(i))) ? lnk_rd : hnext_q[i];
    end
  end

  assign fnext_eff = pend_f_q ? lnk_rd : fnext_q;
  assign cur_head  = head_q[qsel];
  assign cur_tail  = tail_q[qsel];

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    hnext_d    = hnext_eff;
    free_d     = free_q;
    fnext_d    = fnext_eff;
    fill_d     = fill_q;
    pend_f_d   = 1'b0;
    pend_h_d   = 1'b0;
    pend_qid_d = pend_qid_q;
    lwe        = 1'b0;
    lwaddr     = '0;
    lwdata     = PTR_NIL;
    lre        = 1'b0;
    lraddr     = '0;
    dwe        = 1'b0;
    dwaddr     = '0;
    dre        = 1'b0;
    draddr     = '0;
    st         = ST_OK;
    pop_ok     = 1'b0;
    res_head   = PTR_NIL;
    res_tail   = PTR_NIL;
    if (acc && qid_ok) begin
      unique case (cmd_e'(cmd_i))
        CMD_PUSH: begin
          if (free_q.nil) begin
            st = ST_OVERFLOW;
          end else begin
            dwe    = 1'b1;
            dwaddr = free_q.idx;
            free_d = fnext_eff;
            if (!fnext_eff.nil) begin
              lre      = 1'b1;
              lraddr   = fnext_eff.idx;
              pend_f_d = 1'b1;
            end
            if (FILL_W'(free_q.idx) == fill_q) begin
              fill_d = FILL_W'(fill_q + 1'b1);
            end
            if (cur_head.nil) begin
              head_d[qsel] = free_q;
            end else begin
              lwe    = 1'b1;
              lwaddr = cur_tail.idx;
              lwdata = free_q;
              if (cur_head.idx == cur_tail.idx) begin
                hnext_d[qsel] = free_q;
              end
            end
            tail_d[qsel] = free_q;
          end
        end
        CMD_POP: begin
          if (cur_head.nil) begin
            st = ST_UNDERFLOW;
          end else begin
            pop_ok = 1'b1;
            dre    = 1'b1;
            draddr = cur_head.idx;
            if (cur_head.idx == cur_tail.idx) begin
              head_d[qsel] = PTR_NIL;
              tail_d[qsel] = PTR_NIL;
            end else begin
              head_d[qsel] = hnext_eff[qsel];
              lre          = 1'b1;
              lraddr       = hnext_eff[qsel].idx;
              pend_h_d     = 1'b1;
              pend_qid_d   = qsel;
            end
            // slot goes back to the front of the free list
            lwe     = 1'b1;
            lwaddr  = cur_head.idx;
            lwdata  = free_q;
            free_d  = cur_head;
            fnext_d = free_q;
          end
        end
        default: ;
      endcase
      res_head = head_d[qsel];
      res_tail = tail_d[qsel];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lwe) begin
      link_mem[lwaddr] <= lwdata;
    end
    if (lre) begin
      lrd_q   <= link_mem[lraddr];
      laddr_q <= lraddr;
      lvirt_q <= (FILL_W'(lraddr) >= fill_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (dwe) begin
      data_mem[dwaddr] <= value_i;
    end
    if (dre) begin
      drd_q <= data_mem[draddr];
    end
  end

  always_ff @(posedge clk_i) begin
    hnext_q <= hnext_d;
    if (acc) begin
      head_idx_q <= res_head.nil ? '1 : {1'b0, res_head.idx};
      tail_idx_q <= res_tail.nil ? '1 : {1'b0, res_tail.idx};
      status_q   <= st;
      pop_ok_q   <= pop_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= PTR_NIL;
        tail_q[i] <= PTR_NIL;
      end
      free_q      <= '{nil: 1'b0, idx: '0};
      fnext_q     <= '{nil: 1'b0, idx: SLOT_W'(1)};
      fill_q      <= '0;
      pend_f_q    <= 1'b0;
      pend_h_q    <= 1'b0;
      pend_qid_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      free_q     <= free_d;
      fnext_q    <= fnext_d;
      fill_q     <= fill_d;
      pend_f_q   <= pend_f_d;
      pend_h_q   <= pend_h_d;
      pend_qid_q <= pend_qid_d;
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = pop_ok_q ? drd_q : '0;
  assign head_index_o   = head_idx_q;
  assign tail_index_o   = tail_idx_q;

`ifndef SYNTHESIS
  a_one_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_f_q && pend_h_q))
    else $error("free-list and queue lookups pending together");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  a_full_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q.nil |-> (fill_q == FILL_W'(STORE_DEPTH)))
    else $error("free list empty before every slot was allocated");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_q)
    else $error("accepted request left no result");

  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_chk
    a_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
      head_q[g].nil == tail_q[g].nil)
      else $error("queue head and tail disagree on empty");
  end
`endif

endmodule

`default_nettype wire

@@ sim/mqsb_tb_pkg.sv @@
// mqsb_tb_pkg: scoreboard for the multi-queue shared buffer bench
// keeps its own copy of the queue pointers, links, free list and data, predicts each result
// depends on mqsb_pkg
`timescale 1ns / 1ps

package mqsb_tb_pkg;

  import mqsb_pkg::*;

  localparam int QUEUE_COUNT = 4;
  localparam int STORE_SLOTS = 16;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] popped;
    logic signed [4:0]  head;
    logic signed [4:0]  tail;
  } buffer_result_t;

  class shared_buffer_scoreboard;
    logic [31:0]    slot_data[STORE_SLOTS];
    int             slot_next[STORE_SLOTS];
    int             q_head[QUEUE_COUNT];
    int             q_tail[QUEUE_COUNT];
    int             free_slot;
    buffer_result_t expected_results[$];
    int             errors, checked, pushes, pops, overflows, underflows;

    function new();
      for (int i = 0; i < STORE_SLOTS; i++) begin
        slot_data[i] = '0;
        slot_next[i] = (i + 1 < STORE_SLOTS) ? i + 1 : -1;
      end
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        q_head[i] = -1;
        q_tail[i] = -1;
      end
      free_slot = 0;
    endfunction

    function void note_request(logic cmd, logic [1:0] qid, logic [31:0] value);
      buffer_result_t r;
      int at;
      int q;
      q = qid;
      r.status = ST_OK;
      r.popped = '0;
      if (cmd == CMD_PUSH) begin
        pushes++;
        if (free_slot < 0) begin
          r.status = ST_OVERFLOW;
          overflows++;
        end else begin
          at = free_slot;
          slot_data[at] = value;
          free_slot = slot_next[at];
          if (q_head[q] < 0) q_head[q] = at;
          else slot_next[q_tail[q]] = at;
          q_tail[q] = at;
        end
      end else begin
        pops++;
        at = q_head[q];
        if (at < 0) begin
          r.status = ST_UNDERFLOW;
          underflows++;
        end else begin
          r.popped = slot_data[at];
          if (at == q_tail[q]) begin
            q_head[q] = -1;
            q_tail[q] = -1;
          end else begin
            q_head[q] = slot_next[at];
          end
          slot_next[at] = free_slot;
          free_slot = at;
        end
      end
      r.head = q_head[q][4:0];
      r.tail = q_tail[q][4:0];
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic signed [31:0] popped,
                               logic signed [4:0] head, logic signed [4:0] tail);
      buffer_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending (status %0d)", $time, status);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      checked++;
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (popped !== e.popped) begin
        $display("%0t: popped value expected %0d actual %0d", $time, e.popped, popped);
        errors++;
      end
      if (head !== e.head) begin
        $display("%0t: head index expected %0d actual %0d", $time, e.head, head);
        errors++;
      end
      if (tail !== e.tail) begin
        $display("%0t: tail index expected %0d actual %0d", $time, e.tail, tail);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ sim/tb_multi_queue_shared_buffer.sv @@
// tb_multi_queue_shared_buffer: drives push and pop requests into the shared buffer with
// random gaps and output stalls, checks every result against the scoreboard
// depends on mqsb_pkg, mqsb_tb_pkg and multi_queue_shared_buffer
`timescale 1ns / 1ps

module tb_multi_queue_shared_buffer;

  import mqsb_pkg::*;
  import mqsb_tb_pkg::*;

  localparam int BLOCK_REQUESTS = 50;
  localparam int RANDOM_BLOCKS  = 29;
  localparam int PRESSURE_AFTER = 300;
  localparam int PRESSURE_HOLD  = 80;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_stall;
  logic                     cmd;
  logic [1:0]               queue_id;
  logic signed [31:0]       value;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               status;
  logic signed [31:0]       popped_value;
  logic signed [4:0]        head_index;
  logic signed [4:0]        tail_index;

  shared_buffer_scoreboard sb;
  bit                      quiet;
  bit                      pressure_done;

  multi_queue_shared_buffer #(
    .NUM_QUEUES (QUEUE_COUNT),
    .STORE_DEPTH(STORE_SLOTS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .queue_id_i    (queue_id),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .popped_value_o(popped_value),
    .head_index_o  (head_index),
    .tail_index_o  (tail_index)
  );

  always #5 clk_i = ~clk_i;

  function automatic int idle_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // one request per call, waits for its handshake
  task automatic send_request(input logic c, input logic [1:0] q, input logic [31:0] v);
    int gap;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    queue_id <= q;
    value    <= v;
    do @(posedge clk_i); while (in_stall);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_request(cmd, queue_id, value);
      if (out_valid && !out_stall)
        sb.check_result(status, popped_value, head_index, tail_index);
    end
  end

  // receiver: random stall runs, plus one long hold-off to fill the block
  initial begin
    int  run_left;
    bit  stall_run;
    run_left  = 0;
    stall_run = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!pressure_done && sb.checked >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        out_stall <= 1'b1;
        repeat (PRESSURE_HOLD) @(posedge clk_i);
      end else begin
        if (run_left == 0) begin
          stall_run = !quiet && ($urandom_range(0, 2) == 0);
          run_left  = stall_run ? idle_length() : $urandom_range(1, 12);
        end
        out_stall <= stall_run;
        run_left--;
      end
    end
  end

  initial begin
    logic [31:0] boundary_values[16];
    int push_pct;
    int top_queue;
    boundary_values = '{
      32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff,
      32'h00000001, 32'h80000001, 32'h7ffffffe, 32'h55555555,
      32'haaaaaaaa, 32'hfffffffe, 32'h0000ffff, 32'hffff0000,
      32'h00ff00ff, 32'hff00ff00, 32'h12345678, 32'hedcba987
    };
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    cmd           = CMD_PUSH;
    queue_id      = '0;
    value         = '0;
    out_stall     = 1'b0;
    quiet         = 1'b0;
    pressure_done = 1'b0;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // underflow on an empty queue, fill every slot, overflow, drain a queue past empty
    send_request(CMD_POP, 2'd3, 32'h0);
    for (int i = 0; i < 16; i++) send_request(CMD_PUSH, i[1:0], boundary_values[i]);
    send_request(CMD_PUSH, 2'd2, 32'hdeadbeef);
    repeat (5) send_request(CMD_POP, 2'd0, $urandom());

    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      push_pct  = $urandom_range(15, 85);
      top_queue = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 3;
      quiet     = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < BLOCK_REQUESTS; k++) begin
        send_request(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP,
                     2'($urandom_range(0, top_queue)), $urandom());
      end
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("checked %0d results: %0d pushes (%0d overflow), %0d pops (%0d underflow)",
             sb.checked, sb.pushes, sb.overflows, sb.pops, sb.underflows);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout waiting for the block");
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mqsb_pkg.sv
hw/rtl/multi_queue_shared_buffer.sv
sim/mqsb_tb_pkg.sv
sim/tb_multi_queue_shared_buffer.sv
